// ----- rtl/srrxw_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// selective-repeat receive window. No dependencies.
package srrxw_pkg;

  localparam int Window        = 32;
  localparam int MaxSackBlocks = 4;

  localparam int IdxW = $clog2(Window);
  localparam int CntW = $clog2(Window + 1);
  localparam int BlkW = $clog2(MaxSackBlocks + 1);
  localparam int SeqW = 16;
  localparam int RunW = 6;

  localparam logic [1:0] FuncHdr   = 2'd0;
  localparam logic [1:0] FuncAck   = 2'd1;
  localparam logic [1:0] FuncLocal = 2'd2;

  localparam logic [2:0] FtConnect = 3'd0;
  localparam logic [2:0] FtClose   = 3'd1;
  localparam logic [2:0] FtAbort   = 3'd2;
  localparam logic [2:0] FtData    = 3'd3;
  localparam logic [2:0] FtAck     = 3'd4;

  localparam logic [1:0] KindDeliver = 2'd0;
  localparam logic [1:0] KindSack    = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;
  localparam logic [1:0] KindFlush   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       cnt_step;
    logic       del_step;
    logic       sack_step;
    logic       emit;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic want_flush;
    logic want_deliver;
    logic want_sack;
    logic cnt_done;
    logic del_last;
    logic sack_done;
    logic sack_need_emit;
  } sts_t;

endpackage

// ----- rtl/srrxw_ctrl.sv -----
// Sequencer for the receive window: accepts a word, orders the flush,
// delivery, SACK and status results. Depends on srrxw_pkg.
module srrxw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srrxw_pkg::sts_t   sts_i,
  output srrxw_pkg::cmd_t   cmd_o
);
  import srrxw_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_FLUSH   = 3'd2;
  localparam logic [2:0] S_COUNT   = 3'd3;
  localparam logic [2:0] S_DELIVER = 3'd4;
  localparam logic [2:0] S_SACK    = 3'd5;
  localparam logic [2:0] S_STATUS  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = KindStatus;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.want_flush)        state_d = S_FLUSH;
        else if (sts_i.want_deliver) state_d = S_COUNT;
        else if (sts_i.want_sack)    state_d = S_SACK;
        else                         state_d = S_STATUS;
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KindFlush;
          state_d    = S_STATUS;
        end
      end
      S_COUNT: begin
        cmd_o.cnt_step = 1'b1;
        if (sts_i.cnt_done) state_d = S_DELIVER;
      end
      S_DELIVER: begin
        if (sts_i.out_free) begin
          cmd_o.del_step = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KindDeliver;
          if (sts_i.del_last) state_d = S_STATUS;
        end
      end
      S_SACK: begin
        if (sts_i.sack_done) begin
          state_d = S_STATUS;
        end else if (!sts_i.sack_need_emit || sts_i.out_free) begin
          cmd_o.sack_step = 1'b1;
          cmd_o.emit      = sts_i.sack_need_emit;
          cmd_o.kind      = KindSack;
        end
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KindStatus;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result issued into a full output register");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted word not executed");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!cmd_o.emit && !cmd_o.exec))
    else $error("activity while idle");
`endif

endmodule

// ----- rtl/srrxw_dp.sv -----
// Datapath of the receive window: link state, reorder bitmap, drain and
// SACK walkers, output register. Depends on srrxw_pkg.
module srrxw_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        func_i,
  input  logic [2:0]        frame_type_i,
  input  logic [15:0]       seq_i,
  input  logic              local_open_i,
  input  srrxw_pkg::cmd_t   cmd_i,
  output srrxw_pkg::sts_t   sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [15:0]       out_seq_o,
  output logic [5:0]        run_count_o,
  output logic [15:0]       ack_number_o,
  output logic              ack_sent_o,
  output logic              connected_o,
  output logic              last_o
);
  import srrxw_pkg::*;

  // item
  logic [1:0]        func_q;
  logic [2:0]        ftype_q;
  logic [SeqW-1:0]   iseq_q;
  logic              lopen_q;

  // link state
  logic [SeqW-1:0]   ne_q, ne_d;
  logic [Window-1:0] slot_q, slot_d;
  logic              pc_q, pc_d, pcl_q, pcl_d, ap_q, ap_d, sent_q, sent_d;

  // walkers
  logic [Window-1:0] work_q, work_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SeqW-1:0]   eseq_q, eseq_d;
  logic [CntW-1:0]   d_q, d_d, start_q, start_d, run_q, run_d;
  logic              in_run_q, in_run_d;
  logic [BlkW-1:0]   blocks_q, blocks_d;

  // output word
  logic              ov_q;
  logic [1:0]        okind_q;
  logic [SeqW-1:0]   oseq_q, oack_q;
  logic [RunW-1:0]   orun_q;
  logic              osent_q, oconn_q;

  logic [SeqW-1:0]   seq_gap;
  logic              live, in_win, at_end, bitv, need_emit;

  assign seq_gap = iseq_q - ne_q;
  assign live   = pc_q && !pcl_q;
  assign in_win = (seq_gap < SeqW'(Window));
  assign at_end = (d_q == CntW'(Window));
  assign bitv   = work_q[0];
  assign need_emit = in_run_q && (at_end || !bitv);

  always_comb begin
    sts_o = '0;
    sts_o.out_free     = !ov_q || !out_stall_i;
    sts_o.want_flush   = (func_q == FuncHdr) && (ftype_q == FtConnect) && !pc_q;
    sts_o.want_deliver = (func_q == FuncHdr) && (ftype_q == FtData) && live
                         && (seq_gap == '0);
    sts_o.want_sack    = (func_q == FuncAck) && ap_q;
    sts_o.cnt_done     = !work_q[0];
    sts_o.del_last     = (cnt_q == CntW'(1));
    sts_o.sack_done    = (blocks_q == BlkW'(MaxSackBlocks)) || (at_end && !in_run_q);
    sts_o.sack_need_emit = need_emit;
  end

  always_comb begin
    ne_d = ne_q; slot_d = slot_q; pc_d = pc_q; pcl_d = pcl_q; ap_d = ap_q;
    sent_d = sent_q; work_d = work_q; cnt_d = cnt_q; eseq_d = eseq_q;
    d_d = d_q; start_d = start_q; run_d = run_q; in_run_d = in_run_q;
    blocks_d = blocks_q;

    if (cmd_i.exec) begin
      sent_d = 1'b0;
      unique case (func_q)
        FuncHdr: begin
          case (ftype_q) inside
            FtConnect: begin
              if (!pc_q) begin
                ne_d   = '0;
                slot_d = '0;
              end
              pc_d  = 1'b1;
              pcl_d = 1'b0;
              ap_d  = 1'b1;
            end
            FtClose, FtAbort: begin
              if (!(lopen_q && live)) begin
                ap_d = 1'b1;
              end else begin
                pcl_d = 1'b1;
                pc_d  = 1'b0;
              end
            end
            FtData: begin
              if (live) begin
                ap_d = 1'b1;
                if (in_win) begin
                  if (seq_gap != '0) begin
                    slot_d[seq_gap[IdxW-1:0]] = 1'b1;
                  end else begin
                    work_d = slot_q >> 1;
                    cnt_d  = CntW'(1);
                    eseq_d = ne_q;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        FuncAck: begin
          if (ap_q) begin
            ap_d     = 1'b0;
            sent_d   = 1'b1;
            work_d   = slot_q >> 1;
            d_d      = CntW'(1);
            in_run_d = 1'b0;
            blocks_d = '0;
          end
        end
        FuncLocal: begin
          if (lopen_q) begin
            pc_d   = 1'b0;
            slot_d = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.cnt_step) begin
      if (work_q[0]) begin
        cnt_d  = cnt_q + CntW'(1);
        work_d = work_q >> 1;
      end else begin
        ne_d = ne_q + SeqW'(cnt_q);
      end
    end

    if (cmd_i.del_step) begin
      eseq_d = eseq_q + SeqW'(1);
      slot_d = slot_q >> 1;
      cnt_d  = cnt_q - CntW'(1);
    end

    if (cmd_i.sack_step) begin
      if (need_emit) begin
        blocks_d = blocks_q + BlkW'(1);
        in_run_d = 1'b0;
      end
      if (!at_end) begin
        d_d    = d_q + CntW'(1);
        work_d = work_q >> 1;
        if (bitv) begin
          if (!in_run_q) begin
            start_d  = d_q;
            run_d    = CntW'(1);
            in_run_d = 1'b1;
          end else begin
            run_d = run_q + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q     <= '0;
      slot_q   <= '0;
      pc_q     <= 1'b0;
      pcl_q    <= 1'b0;
      ap_q     <= 1'b0;
      sent_q   <= 1'b0;
      work_q   <= '0;
      cnt_q    <= '0;
      d_q      <= '0;
      in_run_q <= 1'b0;
      blocks_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      ne_q     <= ne_d;
      slot_q   <= slot_d;
      pc_q     <= pc_d;
      pcl_q    <= pcl_d;
      ap_q     <= ap_d;
      sent_q   <= sent_d;
      work_q   <= work_d;
      cnt_q    <= cnt_d;
      d_q      <= d_d;
      in_run_q <= in_run_d;
      blocks_q <= blocks_d;
      if (cmd_i.emit)        ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    eseq_q  <= eseq_d;
    start_q <= start_d;
    run_q   <= run_d;
    if (cmd_i.load) begin
      func_q  <= func_i;
      ftype_q <= frame_type_i;
      iseq_q  <= seq_i;
      lopen_q <= local_open_i;
    end
    if (cmd_i.emit) begin
      okind_q <= cmd_i.kind;
      oack_q  <= ne_q;
      oseq_q  <= '0;
      orun_q  <= '0;
      osent_q <= 1'b0;
      oconn_q <= 1'b0;
      unique case (cmd_i.kind)
        KindDeliver: oseq_q <= eseq_q;
        KindSack: begin
          oseq_q <= ne_q + SeqW'(start_q);
          orun_q <= RunW'(run_q);
        end
        KindStatus: begin
          osent_q <= sent_q;
          oconn_q <= live;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign out_seq_o    = oseq_q;
  assign run_count_o  = orun_q;
  assign ack_number_o = oack_q;
  assign ack_sent_o   = osent_q;
  assign connected_o  = oconn_q;
  assign last_o       = (okind_q == KindStatus);

`ifndef SYNTHESIS
  a_blocks_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_q <= BlkW'(MaxSackBlocks))
    else $error("SACK block count beyond limit");
  a_status_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == KindStatus) |-> !slot_q[0])
    else $error("in-order slot left buffered at status");
  a_closed_not_conn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcl_q |-> !pc_q)
    else $error("peer both closed and connected");
  a_del_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.del_step |-> (cnt_q != '0))
    else $error("delivery with empty count");
`endif

endmodule

// ----- rtl/selective_repeat_rx_window.sv -----
// Top level of the selective-repeat receive window with SACK.
// Joins srrxw_ctrl and srrxw_dp; depends on srrxw_pkg.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   func, frame_type, seq, local_open
//   out      out  out_valid_o / out_stall_i kind, out_seq, run_count,
//                                           ack_number, ack_sent, connected, last
//
// One word at a time: load, execute, then each result and a status; a word
// with only a status passes through the load, execute and status states.
// An in-order data word first counts the buffered run, then delivers one segment per
// cycle while the output is free; an ack walks the bitmap one slot per cycle unless a
// SACK block waits on the output. Output stalls hold the sequencer.
// Reset clears all link state and the bitmap at once; no clearing pass.
module selective_repeat_rx_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  frame_type_i,
  input  logic [15:0] seq_i,
  input  logic        local_open_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_seq_o,
  output logic [5:0]  run_count_o,
  output logic [15:0] ack_number_o,
  output logic        ack_sent_o,
  output logic        connected_o,
  output logic        last_o
);
  import srrxw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srrxw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srrxw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .frame_type_i (frame_type_i),
    .seq_i        (seq_i),
    .local_open_i (local_open_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_seq_o    (out_seq_o),
    .run_count_o  (run_count_o),
    .ack_number_o (ack_number_o),
    .ack_sent_o   (ack_sent_o),
    .connected_o  (connected_o),
    .last_o       (last_o)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for selective_repeat_rx_window: directed, full-window,
// back-pressure and random words, checked against an in-bench predictor.
// Depends on srrxw_pkg and the RTL top level only.
module tb_top;
  import srrxw_pkg::*;

  localparam logic [1:0] FuncBad = 2'd3;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 4 * Window;
  localparam int Limit      = 4000;
  localparam int ExpDepth   = 256;
  localparam int MaxRes     = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq_no;
    logic [5:0]  run;
    logic [15:0] ack_no;
    logic        sent;
    logic        up;
    logic        last;
  } rx_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  func = FuncHdr;
  logic [2:0]  frame_type = FtConnect;
  logic [15:0] seq = '0;
  logic        local_open = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [15:0] out_seq;
  logic [5:0]  run_count;
  logic [15:0] ack_number;
  logic        ack_sent;
  logic        connected;
  logic        last;

  // predictor state
  logic [15:0]       exp_seq = '0;
  logic [Window-1:0] slots = '0;
  logic              peer_up = 1'b0;
  logic              peer_gone = 1'b0;
  logic              ack_due = 1'b0;

  // expected results, ring of reports
  rx_report_t exp_mem[ExpDepth];
  int  exp_wr = 0;
  int  exp_rd = 0;
  bit  calm = 1'b0;
  logic hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  pause = 0;
  int  errors = 0;
  int  n_words = 0;
  int  n_results = 0;
  int  n_deliver = 0;
  int  n_sack = 0;
  int  n_flush = 0;
  int  quiet_cyc = 0;

  selective_repeat_rx_window u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .frame_type_i (frame_type),
    .seq_i        (seq),
    .local_open_i (local_open),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .out_seq_o    (out_seq),
    .run_count_o  (run_count),
    .ack_number_o (ack_number),
    .ack_sent_o   (ack_sent),
    .connected_o  (connected),
    .last_o       (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic rx_report_t mk_report(input logic [1:0] k, input logic [15:0] s,
                                           input logic [5:0] r);
    rx_report_t rep;
    rep = '0;
    rep.kind = k;
    rep.seq_no = s;
    rep.run = r;
    return rep;
  endfunction

  task automatic predict_reports(input logic [1:0] fn, input logic [2:0] ft,
                                 input logic [15:0] sq, input logic lo);
    rx_report_t res[MaxRes];
    rx_report_t rep;
    logic [15:0] seq_gap;
    logic sent;
    int d, start, blocks, nres, k;
    sent = 1'b0;
    nres = 0;
    case (fn)
      FuncHdr: begin
        case (ft)
          FtConnect: begin
            if (!peer_up) begin
              exp_seq = '0;
              slots = '0;
              res[nres] = mk_report(KindFlush, '0, '0);
              nres++;
            end
            peer_up = 1'b1;
            peer_gone = 1'b0;
            ack_due = 1'b1;
          end
          FtClose, FtAbort: begin
            if (!(lo && peer_up && !peer_gone)) begin
              ack_due = 1'b1;
            end else begin
              peer_gone = 1'b1;
              peer_up = 1'b0;
            end
          end
          FtData: begin
            if (peer_up && !peer_gone) begin
              ack_due = 1'b1;
              seq_gap = sq - exp_seq;
              if (seq_gap < Window) begin
                if (seq_gap != 0) begin
                  slots[seq_gap[IdxW-1:0]] = 1'b1;
                end else begin
                  res[nres] = mk_report(KindDeliver, exp_seq, '0);
                  nres++;
                  exp_seq = exp_seq + 16'd1;
                  slots = slots >> 1;
                  while (slots[0]) begin
                    res[nres] = mk_report(KindDeliver, exp_seq, '0);
                    nres++;
                    exp_seq = exp_seq + 16'd1;
                    slots = slots >> 1;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
      FuncAck: begin
        if (ack_due) begin
          d = 1;
          blocks = 0;
          while (d < Window && blocks < MaxSackBlocks) begin
            if (slots[d]) begin
              start = d;
              while (d < Window && slots[d]) d++;
              res[nres] = mk_report(KindSack, exp_seq + 16'(start), 6'(d - start));
              nres++;
              blocks++;
            end else begin
              d++;
            end
          end
          ack_due = 1'b0;
          sent = 1'b1;
        end
      end
      FuncLocal: begin
        if (lo) begin
          peer_up = 1'b0;
          slots = '0;
        end
      end
      default: ;
    endcase
    rep = mk_report(KindStatus, '0, '0);
    rep.sent = sent;
    rep.up = peer_up && !peer_gone;
    rep.last = 1'b1;
    res[nres] = rep;
    nres++;
    for (k = 0; k < nres; k++) begin
      res[k].ack_no = exp_seq;
      exp_mem[exp_wr % ExpDepth] = res[k];
      exp_wr++;
    end
  endtask

  task automatic send_word(input logic [1:0] fn, input logic [2:0] ft,
                           input logic [15:0] sq, input logic lo);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func <= fn;
    frame_type <= ft;
    seq <= sq;
    local_open <= lo;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    predict_reports(fn, ft, sq, lo);
    n_words++;
  endtask

  // one random word, mostly data near the window so reordering is exercised
  task automatic send_random_word();
    int pick;
    logic [1:0] fn;
    logic [2:0] ft;
    logic [15:0] sq;
    logic lo;
    pick = $urandom_range(0, 99);
    fn = FuncHdr;
    ft = FtData;
    sq = 16'($urandom);
    lo = ($urandom_range(0, 9) != 0);
    if (!(peer_up && !peer_gone) && pick < 60) begin
      ft = FtConnect;
    end else if (pick < 60) begin
      sq = exp_seq + 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, Window + 4)
                                                       : $urandom_range(0, 6));
    end else if (pick < 64) begin
      ft = FtData;
    end else if (pick < 80) begin
      fn = FuncAck;
    end else if (pick < 84) begin
      ft = FtConnect;
    end else if (pick < 90) begin
      ft = ($urandom_range(0, 1) != 0) ? FtClose : FtAbort;
    end else if (pick < 94) begin
      fn = FuncLocal;
    end else if (pick < 97) begin
      ft = FtAck + 3'($urandom_range(0, 3));
    end else begin
      fn = FuncBad;
    end
    if (fn != FuncHdr) ft = 3'($urandom);
    send_word(fn, ft, sq, lo);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(FuncHdr, FtData, 16'd5, 1'b1);      // no peer yet
    send_word(FuncAck, FtData, 16'd0, 1'b1);      // nothing pending
    send_word(FuncLocal, FtData, 16'd0, 1'b0);    // local already down
    send_word(FuncBad, FtData, 16'hFFFF, 1'b1);
    send_word(FuncHdr, FtClose, 16'd0, 1'b1);     // not established
    send_word(FuncAck, FtData, 16'd0, 1'b1);
    send_word(FuncHdr, FtConnect, 16'd0, 1'b1);
    send_word(FuncHdr, FtConnect, 16'd0, 1'b1);   // same peer, no flush
    send_word(FuncHdr, FtData, 16'd0, 1'b1);
    send_word(FuncHdr, FtData, 16'd3, 1'b1);
    send_word(FuncHdr, FtData, 16'd4, 1'b1);
    send_word(FuncHdr, FtData, 16'd7, 1'b1);
    send_word(FuncHdr, FtData, 16'd9, 1'b1);
    send_word(FuncHdr, FtData, 16'd11, 1'b1);
    send_word(FuncHdr, FtData, 16'd32, 1'b1);     // far edge of window
    send_word(FuncHdr, FtData, 16'd33, 1'b1);     // just outside
    send_word(FuncHdr, FtData, 16'd3, 1'b1);      // duplicate buffered
    send_word(FuncHdr, FtData, 16'd0, 1'b1);      // duplicate behind
    send_word(FuncAck, FtData, 16'd0, 1'b1);      // more runs than blocks
    send_word(FuncHdr, FtData, 16'd1, 1'b1);
    send_word(FuncHdr, FtData, 16'd2, 1'b1);
    send_word(FuncHdr, FtAck, 16'd5, 1'b1);
    send_word(FuncHdr, FtAck + 3'd3, 16'd5, 1'b1);
    send_word(FuncHdr, FtData, 16'hFFFF, 1'b1);
    send_word(FuncHdr, FtAbort, 16'd0, 1'b0);
    send_word(FuncHdr, FtClose, 16'd0, 1'b1);
    send_word(FuncHdr, FtData, 16'd5, 1'b1);      // after close
    send_word(FuncHdr, FtConnect, 16'd0, 1'b1);
    send_word(FuncLocal, FtData, 16'd0, 1'b1);
  endtask

  task automatic test_full_window();
    int order[Window-1];
    int j, k, tmp;
    logic [15:0] base;
    send_word(FuncHdr, FtConnect, 16'd0, 1'b1);
    send_word(FuncAck, FtData, 16'd0, 1'b1);
    base = exp_seq;
    for (k = 0; k < Window - 1; k++) order[k] = k + 1;
    for (k = Window - 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < Window - 1; k++) send_word(FuncHdr, FtData, base + 16'(order[k]), 1'b1);
    send_word(FuncAck, FtData, 16'd0, 1'b1);
    send_word(FuncHdr, FtData, base, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    repeat (40) send_random_word();
  endtask

  task automatic test_random();
    repeat (120) send_random_word();
    wait_drain();
    calm = 1'b1;
    repeat (80) send_random_word();
    calm = 1'b0;
    repeat (120) send_random_word();
  endtask

  task automatic check_report();
    rx_report_t want;
    rx_report_t got;
    got = '{kind, out_seq, run_count, ack_number, ack_sent, connected, last};
    n_results++;
    case (got.kind)
      KindDeliver: n_deliver++;
      KindSack:    n_sack++;
      KindFlush:   n_flush++;
      default: ;
    endcase
    if (exp_wr == exp_rd) begin
      $error("unexpected word: kind %0d out_seq %0d", got.kind, got.seq_no);
      errors++;
    end else begin
      want = exp_mem[exp_rd % ExpDepth];
      exp_rd++;
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.seq_no != want.seq_no) begin
        $error("out_seq: expected %0d, actual %0d", want.seq_no, got.seq_no);
        errors++;
      end
      if (got.run != want.run) begin
        $error("run_count: expected %0d, actual %0d", want.run, got.run);
        errors++;
      end
      if (got.ack_no != want.ack_no) begin
        $error("ack_number: expected %0d, actual %0d", want.ack_no, got.ack_no);
        errors++;
      end
      if (got.sent != want.sent) begin
        $error("ack_sent: expected %0d, actual %0d", want.sent, got.sent);
        errors++;
      end
      if (got.up != want.up) begin
        $error("connected: expected %0d, actual %0d", want.up, got.up);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  // result side: random stalls, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        check_report();
        pause = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold_req && !hold_done) begin
        pause = HoldCycles;
        hold_done = 1'b1;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        pause--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    wait (rst_ni);
    while (quiet_cyc < Limit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cyc = 0;
      else quiet_cyc++;
    end
    $display("timeout after %0d idle cycles", Limit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_window();
    test_backpressure();
    wait_drain();
    test_random();
    wait_drain();
    $display("Covered %0d input words, %0d results: %0d deliveries, %0d SACK blocks, %0d flushes",
             n_words, n_results, n_deliver, n_sack, n_flush);
    $display("Included a full reorder window, a long output hold and a drained pause");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
